// File: design/sqd_pkg.sv
// Shared constants for the shortest-queue dispatch bank.
`default_nettype none
package sqd_pkg;

  localparam int NUM_QUEUES_DEF  = 9;
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 16;

  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

endpackage
`default_nettype wire

// File: design/sqd_if.sv
// Valid/ready channel interfaces for the request and result sides.
`default_nettype none
interface sqd_in_if #(
  parameter int VALUE_WIDTH = sqd_pkg::VALUE_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [VALUE_WIDTH-1:0] item_value;

  modport source (output valid, op, item_value, input ready);
  modport sink   (input valid, op, item_value, output ready);
endinterface

interface sqd_out_if #(
  parameter int IDX_W       = 4,
  parameter int VALUE_WIDTH = sqd_pkg::VALUE_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [IDX_W-1:0]             queue_index;
  logic [VALUE_WIDTH-1:0]       popped_value;
  logic [sqd_pkg::STATUS_W-1:0] status;

  modport source (output valid, queue_index, popped_value, status, input ready);
  modport sink   (input valid, queue_index, popped_value, status, output ready);
endinterface
`default_nettype wire

// File: design/sqd_entry_ram.sv
// Single-port entry store for all queues, registered read data.
`default_nettype none
module sqd_entry_ram #(
  parameter int DEPTH       = 288,
  parameter int VALUE_WIDTH = 16,
  parameter int AW          = $clog2(DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          addr,
  input  wire logic [VALUE_WIDTH-1:0] wdata,
  output logic      [VALUE_WIDTH-1:0] rdata
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: design/sqd_select.sv
// Registered min/max occupancy compare tree, lowest index wins ties.
`default_nettype none
module sqd_select #(
  parameter int NUM_QUEUES  = 9,
  parameter int QUEUE_DEPTH = 32,
  parameter int IDX_W       = $clog2(NUM_QUEUES),
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [NUM_QUEUES*CW-1:0] occ_flat,
  output logic      [IDX_W-1:0]         min_idx,
  output logic      [IDX_W-1:0]         max_idx,
  output logic                          all_full,
  output logic                          all_empty
);

  localparam int LV = IDX_W;
  localparam int P  = 1 << IDX_W;

  logic [CW-1:0]    lo_occ [LV+1][P];
  logic [IDX_W-1:0] lo_idx [LV+1][P];
  logic [CW-1:0]    hi_occ [LV+1][P];
  logic [IDX_W-1:0] hi_idx [LV+1][P];

  // Pad unused leaves so they never win: they sit above every real index.
  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < NUM_QUEUES) begin : g_real
      assign lo_occ[0][i] = occ_flat[i*CW +: CW];
      assign hi_occ[0][i] = occ_flat[i*CW +: CW];
    end else begin : g_pad
      assign lo_occ[0][i] = '1;
      assign hi_occ[0][i] = '0;
    end
    assign lo_idx[0][i] = IDX_W'(i);
    assign hi_idx[0][i] = IDX_W'(i);
  end

  for (genvar l = 0; l < LV; l++) begin : g_lvl
    for (genvar n = 0; n < (P >> (l + 1)); n++) begin : g_node
      logic lo_b;
      logic hi_b;
      assign lo_b = lo_occ[l][2*n+1] < lo_occ[l][2*n];
      assign hi_b = hi_occ[l][2*n+1] > hi_occ[l][2*n];
      assign lo_occ[l+1][n] = lo_b ? lo_occ[l][2*n+1] : lo_occ[l][2*n];
      assign lo_idx[l+1][n] = lo_b ? lo_idx[l][2*n+1] : lo_idx[l][2*n];
      assign hi_occ[l+1][n] = hi_b ? hi_occ[l][2*n+1] : hi_occ[l][2*n];
      assign hi_idx[l+1][n] = hi_b ? hi_idx[l][2*n+1] : hi_idx[l][2*n];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_idx   <= '0;
      max_idx   <= '0;
      all_full  <= 1'b0;
      all_empty <= 1'b1;
    end else begin
      min_idx   <= lo_idx[LV][0];
      max_idx   <= hi_idx[LV][0];
      all_full  <= lo_occ[LV][0] == CW'(QUEUE_DEPTH);
      all_empty <= hi_occ[LV][0] == '0;
    end
  end

endmodule
`default_nettype wire

// File: design/shortest_queue_dispatch_bank_core.sv
// Top level: sequencer, queue pointers and occupancy around the entry store.
//
// Bank of NUM_QUEUES circular FIFOs, QUEUE_DEPTH entries each. An insert
// goes to the emptiest queue and a remove pops the fullest one, ties to the
// lowest index; an insert with every queue full comes back with status 1 and
// is dropped, a remove with every queue empty comes back with status 2. One
// item is in flight at a time and goes through these steps before the
// next acceptance: the occupancy compare tree is registered, the
// single-port entry store is read or written, and the result register is
// loaded. The result register lets the next item be accepted while a
// result still waits; a result not taken stalls the load of the result
// register. No clearing pass is needed after reset.
`default_nettype none
module shortest_queue_dispatch_bank_core #(
  parameter int NUM_QUEUES  = sqd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF,
  parameter int VALUE_WIDTH = sqd_pkg::VALUE_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  sqd_in_if.sink    in_ch,
  sqd_out_if.source out_ch
);
  import sqd_pkg::*;

  localparam int IDX_W = $clog2(NUM_QUEUES);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PICK = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]             state;
  logic                   op_reg;
  logic [VALUE_WIDTH-1:0] value_reg;
  logic [IDX_W-1:0]       q_reg;
  logic                   fail_reg;

  logic [PW-1:0] head [NUM_QUEUES];
  logic [PW-1:0] tail [NUM_QUEUES];
  logic [CW-1:0] occ  [NUM_QUEUES];
  logic [NUM_QUEUES*CW-1:0] occ_flat;

  logic [IDX_W-1:0] min_idx;
  logic [IDX_W-1:0] max_idx;
  logic             all_full;
  logic             all_empty;

  logic [IDX_W-1:0] q;
  logic             fail;
  logic [PW-1:0]    ptr;
  logic [PW-1:0]    ptr_next;
  logic             we;
  logic             re;
  logic [AW-1:0]    addr;
  logic [VALUE_WIDTH-1:0] rdata;
  logic             out_load;

  logic                   out_valid;
  logic [IDX_W-1:0]       out_idx;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [STATUS_W-1:0]    out_status;

  for (genvar i = 0; i < NUM_QUEUES; i++) begin : g_flat
    assign occ_flat[i*CW +: CW] = occ[i];
  end

  sqd_select #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDX_W       (IDX_W),
    .CW          (CW)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .occ_flat  (occ_flat),
    .min_idx   (min_idx),
    .max_idx   (max_idx),
    .all_full  (all_full),
    .all_empty (all_empty)
  );

  assign in_ch.ready = state == S_IDLE;

  assign q        = (op_reg == OP_REMOVE) ? max_idx : min_idx;
  assign fail     = (op_reg == OP_REMOVE) ? all_empty : all_full;
  assign ptr      = (op_reg == OP_REMOVE) ? head[q] : tail[q];
  assign ptr_next = (ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr + PW'(1);
  assign we       = state == S_PICK && op_reg == OP_INSERT && !fail;
  assign re       = state == S_PICK && op_reg == OP_REMOVE && !fail;
  assign addr     = AW'(q) * AW'(QUEUE_DEPTH) + AW'(ptr);
  assign out_load = state == S_EMIT && (!out_valid || out_ch.ready);

  sqd_entry_ram #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .re    (re),
    .addr  (addr),
    .wdata (value_reg),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            state <= S_PICK;
          end
        end
        S_PICK: state <= S_EMIT;
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      op_reg    <= in_ch.op;
      value_reg <= in_ch.item_value;
    end
    if (state == S_PICK) begin
      q_reg    <= q;
      fail_reg <= fail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        occ[i]  <= '0;
      end
    end else if (we) begin
      tail[q] <= ptr_next;
      occ[q]  <= occ[q] + CW'(1);
    end else if (re) begin
      head[q] <= ptr_next;
      occ[q]  <= occ[q] - CW'(1);
    end
  end

  // Hold the result until taken; a failed item reports queue zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx   <= fail_reg ? '0 : q_reg;
      out_value <= (op_reg == OP_REMOVE && !fail_reg) ? rdata : '0;
      priority if (!fail_reg) begin
        out_status <= ST_DONE;
      end else if (op_reg == OP_REMOVE) begin
        out_status <= ST_EMPTY;
      end else begin
        out_status <= ST_FULL;
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.queue_index  = out_idx;
  assign out_ch.popped_value = out_value;
  assign out_ch.status       = out_status;

`ifndef NO_ASSERTIONS
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_DONE |-> out_idx == '0 && out_value == '0)
    else $error("failed item reports nonzero index or value");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(we && re))
    else $error("entry store read and written in the same cycle");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(all_full && all_empty))
    else $error("bank seen both full and empty");

  a_pick_once: assert property (@(posedge clk) disable iff (rst)
    state == S_PICK |=> state == S_EMIT)
    else $error("store access stage not followed by result stage");
`endif

endmodule
`default_nettype wire
